// File: rtl/i2c_master_byte_sequencer_core_defines.svh
// ---------------------------------------------------------------------------
// I2C master byte sequencer: assertion macros
// Shared property macros for the sequencer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define I2CMBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define I2CMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2cmbs_pkg.sv
// ---------------------------------------------------------------------------
// I2C master byte sequencer package
// Mode and register codes, reset values and the word structs shared by
// the sequencer modules.
// ---------------------------------------------------------------------------
package i2cmbs_pkg;

  // Mode codes of an input word (six and seven behave as a tick)
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_START    = 3'd1;
  localparam logic [2:0] MODE_STOP     = 3'd2;
  localparam logic [2:0] MODE_WRITE    = 3'd3;
  localparam logic [2:0] MODE_READ_ACK = 3'd4;
  localparam logic [2:0] MODE_READ_NAK = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_BIT_PHASE  = 3'd0;
  localparam logic [2:0] REG_READ_HIGH  = 3'd1;
  localparam logic [2:0] REG_READ_LOW   = 3'd2;
  localparam logic [2:0] REG_START_HOLD = 3'd3;
  localparam logic [2:0] REG_POLL_LIMIT = 3'd4;
  localparam logic [2:0] REG_POST_ACK   = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_BIT_PHASE  = 8'd2;
  localparam logic [7:0] RST_READ_HIGH  = 8'd4;
  localparam logic [7:0] RST_READ_LOW   = 8'd4;
  localparam logic [7:0] RST_START_HOLD = 8'd4;
  localparam logic [7:0] RST_POLL_LIMIT = 8'd250;
  localparam logic [7:0] RST_POST_ACK   = 8'd20;

  // Delays as the sequencer uses them; the first four never read zero
  typedef struct packed {
    logic [7:0] bit_phase;
    logic [7:0] read_high;
    logic [7:0] read_low;
    logic [7:0] start_hold;
    logic [7:0] poll_limit;
    logic [7:0] post_ack;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  // One result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_error;
    logic       cmd_rejected;
  } res_t;

endpackage

// File: rtl/i2c_master_byte_sequencer_core.sv
// ---------------------------------------------------------------------------
// I2C master byte sequencer core
// Byte-level I2C master stepped by a one-microsecond tick word.
// ---------------------------------------------------------------------------
// Each input word is a tick (carrying the sampled SDA) or a command: start,
// stop, write byte with ACK polling, or read byte answered with ACK or NACK.
// Every word produces exactly one result word with the SCL/SDA drive and
// status. One word is taken per clock while the input is not stalled: it
// lands in an input register, the sequencer steps once on it when the
// result register is free or being read, and the result is held in that
// output register. The input register keeps accepting while a result waits,
// and only stalls when both registers are full and the output is stalled.
// Write the configuration registers only while no word is in flight.
// ---------------------------------------------------------------------------
`include "i2c_master_byte_sequencer_core_defines.svh"

module i2c_master_byte_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] in_mode_i,
  input  logic [7:0] in_tx_byte_i,
  input  logic       in_sda_in_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_scl_level_o,
  output logic       out_sda_level_o,
  output logic       out_busy_res_o,
  output logic       out_done_res_o,
  output logic [7:0] out_rx_byte_o,
  output logic       out_ack_error_o,
  output logic       out_cmd_rejected_o
);
  import i2cmbs_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  res_t  res_d, res_q;
  logic  in_vld_q, out_vld_q;
  logic  in_take, step;

  // Handshake: step when a word is held and the result slot frees up
  assign step       = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & out_vld_q & out_stall_i;
  assign in_take    = in_valid_i & ~in_stall_o;

  i2cmbs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  i2cmbs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode    <= in_mode_i;
      item_q.tx_byte <= in_tx_byte_i;
      item_q.sda_in  <= in_sda_in_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign out_scl_level_o    = res_q.scl_level;
  assign out_sda_level_o    = res_q.sda_level;
  assign out_busy_res_o     = res_q.busy;
  assign out_done_res_o     = res_q.done;
  assign out_rx_byte_o      = res_q.rx_byte;
  assign out_ack_error_o    = res_q.ack_error;
  assign out_cmd_rejected_o = res_q.cmd_rejected;

  // Checks
  `I2CMBS_ASSERT_NOW(a_stall_cause, in_stall_o, out_vld_q && out_stall_i, "input stalled without a blocked result")
  `I2CMBS_ASSERT_NEXT(a_step_result, step, out_vld_q, "step taken but no result registered")
  `I2CMBS_ASSERT_NOW(a_done_idle, out_vld_q && res_q.done, !res_q.busy, "done reported while still busy")
  `I2CMBS_ASSERT_NOW(a_done_rej, out_vld_q && res_q.cmd_rejected, !res_q.done && res_q.busy, "rejection outside a busy period")

endmodule

// File: rtl/i2cmbs_cfg_regs.sv
// ---------------------------------------------------------------------------
// I2C master byte sequencer configuration registers
// Six 8-bit delay and limit registers behind a plain write port; zero
// bit-phase, read and start-hold delays are presented as one.
// ---------------------------------------------------------------------------
module i2cmbs_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output i2cmbs_pkg::cfg_t  cfg_o
);
  import i2cmbs_pkg::*;

  logic [7:0] bit_phase_q, read_high_q, read_low_q;
  logic [7:0] start_hold_q, poll_limit_q, post_ack_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_phase_q  <= RST_BIT_PHASE;
      read_high_q  <= RST_READ_HIGH;
      read_low_q   <= RST_READ_LOW;
      start_hold_q <= RST_START_HOLD;
      poll_limit_q <= RST_POLL_LIMIT;
      post_ack_q   <= RST_POST_ACK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIT_PHASE:  bit_phase_q  <= cfg_data_i;
        REG_READ_HIGH:  read_high_q  <= cfg_data_i;
        REG_READ_LOW:   read_low_q   <= cfg_data_i;
        REG_START_HOLD: start_hold_q <= cfg_data_i;
        REG_POLL_LIMIT: poll_limit_q <= cfg_data_i;
        REG_POST_ACK:   post_ack_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Delay of zero counts as one tick; limit and post-ACK pass raw
  assign cfg_o.bit_phase  = (bit_phase_q  == 8'd0) ? 8'd1 : bit_phase_q;
  assign cfg_o.read_high  = (read_high_q  == 8'd0) ? 8'd1 : read_high_q;
  assign cfg_o.read_low   = (read_low_q   == 8'd0) ? 8'd1 : read_low_q;
  assign cfg_o.start_hold = (start_hold_q == 8'd0) ? 8'd1 : start_hold_q;
  assign cfg_o.poll_limit = poll_limit_q;
  assign cfg_o.post_ack   = post_ack_q;

endmodule

// File: rtl/i2cmbs_seq.sv
// ---------------------------------------------------------------------------
// I2C master byte sequencer state machine
// Holds the bus phase, counters and shift register, and takes one step
// per word: a command starts a sequence if idle, a tick steps the waveform.
// ---------------------------------------------------------------------------
module i2cmbs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  i2cmbs_pkg::item_t item_i,
  input  i2cmbs_pkg::cfg_t  cfg_i,
  output i2cmbs_pkg::res_t  res_o
);
  import i2cmbs_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
    PH_W_LOW, PH_W_HIGH, PH_ACK_POLL, PH_POST_ACK,
    PH_R_PRE, PH_R_HIGH, PH_R_HOLD, PH_R_LOW, PH_R_ACK
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] tick_q, tick_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] poll_q, poll_d;
  logic       send_ack_q, send_ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       err_q, err_d;
  logic [7:0] rx_q, rx_d;
  logic       is_cmd, done, rejected;
  logic [3:0] bit_inc;

  assign is_cmd  = (item_i.mode == MODE_START) || (item_i.mode == MODE_STOP) ||
                   (item_i.mode == MODE_WRITE) || (item_i.mode == MODE_READ_ACK) ||
                   (item_i.mode == MODE_READ_NAK);
  assign bit_inc = bit_idx_q + 4'd1;

  // Next state for one word
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    poll_d     = poll_q;
    send_ack_d = send_ack_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    err_d      = err_q;
    rx_d       = rx_q;
    done       = 1'b0;
    rejected   = 1'b0;

    if (is_cmd) begin
      if (phase_q != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        err_d = 1'b0;
        case (item_i.mode)
          MODE_START: begin
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            tick_d  = cfg_i.start_hold;
            phase_d = PH_START_A;
          end
          MODE_STOP: begin
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            tick_d  = cfg_i.start_hold;
            phase_d = PH_STOP_A;
          end
          MODE_WRITE: begin
            scl_d     = 1'b0;
            bit_idx_d = 4'd0;
            sda_d     = item_i.tx_byte[7];
            shift_d   = {item_i.tx_byte[6:0], 1'b0};
            tick_d    = cfg_i.bit_phase;
            phase_d   = PH_W_LOW;
          end
          default: begin
            // either read flavour
            send_ack_d = (item_i.mode == MODE_READ_ACK);
            scl_d      = 1'b0;
            sda_d      = 1'b1;
            shift_d    = 8'd0;
            bit_idx_d  = 4'd0;
            tick_d     = cfg_i.read_low;
            phase_d    = PH_R_PRE;
          end
        endcase
      end
    end else if (phase_q != PH_IDLE) begin
      if (tick_q > 8'd1) begin
        tick_d = tick_q - 8'd1;
      end else begin
        tick_d = 8'd0;
        unique case (phase_q)
          PH_START_A: begin
            sda_d   = 1'b0;
            tick_d  = cfg_i.start_hold;
            phase_d = PH_START_B;
          end
          PH_START_B: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          PH_STOP_A: begin
            scl_d   = 1'b1;
            tick_d  = cfg_i.start_hold;
            phase_d = PH_STOP_B;
          end
          PH_STOP_B: begin
            sda_d   = 1'b1;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          PH_W_LOW: begin
            scl_d   = 1'b1;
            tick_d  = cfg_i.bit_phase;
            phase_d = PH_W_HIGH;
          end
          PH_W_HIGH: begin
            scl_d     = 1'b0;
            bit_idx_d = bit_inc;
            if (bit_inc < 4'd8) begin
              sda_d   = shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
              tick_d  = cfg_i.bit_phase;
              phase_d = PH_W_LOW;
            end else begin
              // release SDA and clock for the ACK bit
              sda_d   = 1'b1;
              scl_d   = 1'b1;
              poll_d  = 8'd0;
              tick_d  = 8'd1;
              phase_d = PH_ACK_POLL;
            end
          end
          PH_ACK_POLL: begin
            if (!item_i.sda_in) begin
              scl_d = 1'b0;
              if (cfg_i.post_ack == 8'd0) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end else begin
                tick_d  = cfg_i.post_ack;
                phase_d = PH_POST_ACK;
              end
            end else if (poll_q >= cfg_i.poll_limit) begin
              // timeout: flag and send a stop
              err_d   = 1'b1;
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              tick_d  = cfg_i.start_hold;
              phase_d = PH_STOP_A;
            end else begin
              poll_d = poll_q + 8'd1;
              tick_d = cfg_i.bit_phase;
            end
          end
          PH_POST_ACK: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          PH_R_PRE, PH_R_LOW: begin
            scl_d = 1'b1;
            if (phase_q == PH_R_LOW && bit_idx_q >= 4'd8) begin
              sda_d   = ~send_ack_q;
              tick_d  = cfg_i.bit_phase;
              phase_d = PH_R_ACK;
            end else begin
              tick_d  = cfg_i.read_high;
              phase_d = PH_R_HIGH;
            end
          end
          PH_R_HIGH: begin
            shift_d = {shift_q[6:0], item_i.sda_in};
            tick_d  = cfg_i.bit_phase;
            phase_d = PH_R_HOLD;
          end
          PH_R_HOLD: begin
            scl_d     = 1'b0;
            bit_idx_d = bit_inc;
            tick_d    = cfg_i.read_low;
            phase_d   = PH_R_LOW;
          end
          PH_R_ACK: begin
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            rx_d    = shift_q;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= 8'd0;
      bit_idx_q  <= 4'd0;
      shift_q    <= 8'd0;
      poll_q     <= 8'd0;
      send_ack_q <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      err_q      <= 1'b0;
      rx_q       <= 8'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      poll_q     <= poll_d;
      send_ack_q <= send_ack_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      err_q      <= err_d;
      rx_q       <= rx_d;
    end
  end

  // Result word as seen after this step
  assign res_o.scl_level    = scl_d;
  assign res_o.sda_level    = sda_d;
  assign res_o.busy         = (phase_d != PH_IDLE);
  assign res_o.done         = done;
  assign res_o.rx_byte      = rx_d;
  assign res_o.ack_error    = err_d;
  assign res_o.cmd_rejected = rejected;

endmodule

// File: dv/i2c_master_byte_sequencer_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// I2C master byte sequencer core testbench
// Drives tick and command words into the sequencer and predicts the SCL/SDA
// drive and status word that each one produces. Directed tests cover reset
// and zero delays, ACK timeout, the widest hold and post-ACK delays and
// back-pressure. Random command sequences run under three idling patterns
// and several settings.
// ---------------------------------------------------------------------------
module i2c_master_byte_sequencer_core_test;
  import i2cmbs_pkg::*;

  // Undefined modes, which the sequencer treats as a tick
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 3000;

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_STOP_A, SEQ_STOP_B,
    SEQ_W_LOW, SEQ_W_HIGH, SEQ_ACK_POLL, SEQ_POST_ACK,
    SEQ_R_PRE, SEQ_R_HIGH, SEQ_R_HOLD, SEQ_R_LOW, SEQ_R_ACK
  } seq_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = REG_BIT_PHASE;
  logic [7:0] cfg_data_i = 8'd0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] in_mode_i = MODE_TICK;
  logic [7:0] in_tx_byte_i = 8'd0;
  logic       in_sda_in_i = 1'b1;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       out_scl_level_o;
  logic       out_sda_level_o;
  logic       out_busy_res_o;
  logic       out_done_res_o;
  logic [7:0] out_rx_byte_o;
  logic       out_ack_error_o;
  logic       out_cmd_rejected_o;

  i2c_master_byte_sequencer_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_mode_i          (in_mode_i),
    .in_tx_byte_i       (in_tx_byte_i),
    .in_sda_in_i        (in_sda_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_scl_level_o    (out_scl_level_o),
    .out_sda_level_o    (out_sda_level_o),
    .out_busy_res_o     (out_busy_res_o),
    .out_done_res_o     (out_done_res_o),
    .out_rx_byte_o      (out_rx_byte_o),
    .out_ack_error_o    (out_ack_error_o),
    .out_cmd_rejected_o (out_cmd_rejected_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state and settings
  cfg_t cfg = '{bit_phase: RST_BIT_PHASE, read_high: RST_READ_HIGH,
                read_low: RST_READ_LOW, start_hold: RST_START_HOLD,
                poll_limit: RST_POLL_LIMIT, post_ack: RST_POST_ACK};
  seq_phase_e seq_phase = SEQ_IDLE;
  logic [7:0] tick_cnt = 8'd0;
  logic [3:0] bit_cnt = 4'd0;
  logic [7:0] shreg = 8'd0;
  logic [7:0] polls = 8'd0;
  logic       ack_on_read = 1'b0;
  logic       scl_q = 1'b1;
  logic       sda_q = 1'b1;
  logic       err_q = 1'b0;
  logic [7:0] rx_q = 8'd0;

  res_t bus_states_due[$];
  res_t head_state;
  int   mismatches = 0;
  int   results_seen = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   holdoff_left = 0;
  int   quiet_cycles = 0;

  function automatic logic [7:0] at_least_1(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic void shift_out_bit();
    sda_q = shreg[7];
    shreg = {shreg[6:0], 1'b0};
    tick_cnt = at_least_1(cfg.bit_phase);
    seq_phase = SEQ_W_LOW;
  endfunction

  function automatic void begin_stop();
    scl_q = 1'b0;
    sda_q = 1'b0;
    tick_cnt = at_least_1(cfg.start_hold);
    seq_phase = SEQ_STOP_A;
  endfunction

  // Current delay expired: next waveform step; returns 1 when the command ends
  function automatic logic advance_step(input logic sda);
    logic fin;
    fin = 1'b0;
    case (seq_phase)
      SEQ_START_A: begin
        sda_q = 1'b0;
        tick_cnt = at_least_1(cfg.start_hold);
        seq_phase = SEQ_START_B;
      end
      SEQ_START_B: begin
        seq_phase = SEQ_IDLE;
        fin = 1'b1;
      end
      SEQ_STOP_A: begin
        scl_q = 1'b1;
        tick_cnt = at_least_1(cfg.start_hold);
        seq_phase = SEQ_STOP_B;
      end
      SEQ_STOP_B: begin
        sda_q = 1'b1;
        seq_phase = SEQ_IDLE;
        fin = 1'b1;
      end
      SEQ_W_LOW: begin
        scl_q = 1'b1;
        tick_cnt = at_least_1(cfg.bit_phase);
        seq_phase = SEQ_W_HIGH;
      end
      SEQ_W_HIGH: begin
        scl_q = 1'b0;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < 4'd8) begin
          shift_out_bit();
        end else begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          polls = 8'd0;
          tick_cnt = 8'd1;
          seq_phase = SEQ_ACK_POLL;
        end
      end
      SEQ_ACK_POLL: begin
        if (sda == 1'b0) begin
          scl_q = 1'b0;
          if (cfg.post_ack == 8'd0) begin
            seq_phase = SEQ_IDLE;
            fin = 1'b1;
          end else begin
            tick_cnt = cfg.post_ack;
            seq_phase = SEQ_POST_ACK;
          end
        end else if (polls >= cfg.poll_limit) begin
          err_q = 1'b1;
          begin_stop();
        end else begin
          polls = polls + 8'd1;
          tick_cnt = at_least_1(cfg.bit_phase);
        end
      end
      SEQ_POST_ACK: begin
        seq_phase = SEQ_IDLE;
        fin = 1'b1;
      end
      SEQ_R_PRE, SEQ_R_LOW: begin
        if (seq_phase == SEQ_R_LOW && bit_cnt >= 4'd8) begin
          sda_q = ack_on_read ? 1'b0 : 1'b1;
          scl_q = 1'b1;
          tick_cnt = at_least_1(cfg.bit_phase);
          seq_phase = SEQ_R_ACK;
        end else begin
          scl_q = 1'b1;
          tick_cnt = at_least_1(cfg.read_high);
          seq_phase = SEQ_R_HIGH;
        end
      end
      SEQ_R_HIGH: begin
        shreg = {shreg[6:0], sda};
        tick_cnt = at_least_1(cfg.bit_phase);
        seq_phase = SEQ_R_HOLD;
      end
      SEQ_R_HOLD: begin
        scl_q = 1'b0;
        bit_cnt = bit_cnt + 4'd1;
        tick_cnt = at_least_1(cfg.read_low);
        seq_phase = SEQ_R_LOW;
      end
      SEQ_R_ACK: begin
        scl_q = 1'b0;
        sda_q = 1'b1;
        rx_q = shreg;
        seq_phase = SEQ_IDLE;
        fin = 1'b1;
      end
      default: seq_phase = SEQ_IDLE;
    endcase
    return fin;
  endfunction

  // Steps the predicted sequencer on one accepted word; returns the bus state
  function automatic res_t step_sequencer(input item_t it);
    res_t r;
    logic fin;
    logic rej;
    fin = 1'b0;
    rej = 1'b0;
    if (it.mode >= MODE_START && it.mode <= MODE_READ_NAK) begin
      if (seq_phase != SEQ_IDLE) begin
        rej = 1'b1;
      end else begin
        err_q = 1'b0;
        case (it.mode)
          MODE_START: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
            tick_cnt = at_least_1(cfg.start_hold);
            seq_phase = SEQ_START_A;
          end
          MODE_STOP: begin_stop();
          MODE_WRITE: begin
            scl_q = 1'b0;
            shreg = it.tx_byte;
            bit_cnt = 4'd0;
            shift_out_bit();
          end
          default: begin
            ack_on_read = (it.mode == MODE_READ_ACK);
            scl_q = 1'b0;
            sda_q = 1'b1;
            shreg = 8'd0;
            bit_cnt = 4'd0;
            tick_cnt = at_least_1(cfg.read_low);
            seq_phase = SEQ_R_PRE;
          end
        endcase
      end
    end else if (seq_phase != SEQ_IDLE) begin
      if (tick_cnt > 8'd1) begin
        tick_cnt = tick_cnt - 8'd1;
      end else begin
        tick_cnt = 8'd0;
        fin = advance_step(it.sda_in);
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy = (seq_phase != SEQ_IDLE);
    r.done = fin;
    r.rx_byte = rx_q;
    r.ack_error = err_q;
    r.cmd_rejected = rej;
    return r;
  endfunction

  // SDA seen on a tick: ACK chance while polling, else a low-level chance
  function automatic logic pick_sda(input int ack_pct, input int low_pct);
    if (seq_phase == SEQ_ACK_POLL) return ($urandom_range(0, 99) < ack_pct) ? 1'b0 : 1'b1;
    return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
  endtask

  // Offers one word, waits for it to be taken and predicts its result
  task automatic send_word(input logic [2:0] mode, input logic [7:0] tx, input logic sda);
    item_t it;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_mode_i    <= mode;
    in_tx_byte_i <= tx;
    in_sda_in_i  <= sda;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    it.mode = mode;
    it.tx_byte = tx;
    it.sda_in = sda;
    bus_states_due.push_back(step_sequencer(it));
  endtask

  // Ticks until the predicted sequencer has finished its command
  task automatic run_to_idle(input int ack_pct, input int low_pct);
    while (seq_phase != SEQ_IDLE)
      send_word(MODE_TICK, 8'($urandom_range(0, 255)), pick_sda(ack_pct, low_pct));
  endtask

  // Input released, every result in, pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (bus_states_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_BIT_PHASE:  cfg.bit_phase = val;
      REG_READ_HIGH:  cfg.read_high = val;
      REG_READ_LOW:   cfg.read_low = val;
      REG_START_HOLD: cfg.start_hold = val;
      REG_POLL_LIMIT: cfg.poll_limit = val;
      default:        cfg.post_ack = val;
    endcase
  endtask

  task automatic program_settings(input logic [7:0] bp, input logic [7:0] rh,
                                  input logic [7:0] rl, input logic [7:0] sh,
                                  input logic [7:0] pl, input logic [7:0] pa);
    settle();
    put_reg(REG_BIT_PHASE, bp);
    put_reg(REG_READ_HIGH, rh);
    put_reg(REG_READ_LOW, rl);
    put_reg(REG_START_HOLD, sh);
    put_reg(REG_POLL_LIMIT, pl);
    put_reg(REG_POST_ACK, pa);
    cfg_we_i <= 1'b0;
  endtask

  // Reset settings: idle tick, start with a rejected stop, spare modes, stop, write
  task automatic test_reset_settings();
    send_word(MODE_TICK, 8'h00, 1'b0);
    send_word(MODE_START, 8'hFF, 1'b1);
    send_word(MODE_STOP, 8'h00, 1'b0);
    send_word(MODE_SPARE_LO, 8'h00, 1'b1);
    send_word(MODE_SPARE_HI, 8'hFF, 1'b0);
    run_to_idle(50, 50);
    send_word(MODE_STOP, 8'h00, 1'b1);
    run_to_idle(50, 50);
    send_word(MODE_WRITE, 8'hA5, 1'b1);
    run_to_idle(20, 50);
    settle();
  endtask

  // All delays zero: the first four act as one, finish on the ACK tick, abort on first miss
  task automatic test_zero_delays();
    program_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_word(MODE_WRITE, 8'h00, 1'b0);
    run_to_idle(100, 50);
    send_word(MODE_WRITE, 8'hFF, 1'b0);
    run_to_idle(0, 50);
    send_word(MODE_READ_ACK, 8'hFF, 1'b1);
    run_to_idle(50, 100);
    send_word(MODE_READ_NAK, 8'h00, 1'b0);
    run_to_idle(50, 0);
    send_word(MODE_START, 8'h00, 1'b0);
    run_to_idle(50, 50);
    send_word(MODE_STOP, 8'h00, 1'b0);
    run_to_idle(50, 50);
    settle();
  endtask

  // Longest poll run ending in abort, then a late ACK and an error-clearing read
  task automatic test_ack_timeout();
    program_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd255, 8'd1);
    send_word(MODE_WRITE, 8'h5A, 1'b1);
    run_to_idle(0, 50);
    send_word(MODE_WRITE, 8'hC3, 1'b1);
    run_to_idle(2, 50);
    send_word(MODE_READ_ACK, 8'h00, 1'b1);
    run_to_idle(50, 50);
    settle();
  endtask

  // Widest start hold, poll limit and post-ACK delay
  task automatic test_wide_delays();
    program_settings(8'd1, 8'd1, 8'd1, 8'd255, 8'd255, 8'd255);
    send_word(MODE_START, 8'h00, 1'b1);
    run_to_idle(50, 50);
    send_word(MODE_WRITE, 8'h81, 1'b0);
    run_to_idle(50, 50);
    send_word(MODE_READ_ACK, 8'h00, 1'b0);
    run_to_idle(50, 50);
    settle();
  endtask

  // Long receiver hold-off with the sender pushing, then a full drain
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    holdoff_left = 80;
    send_word(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b1);
    repeat (30) send_word(MODE_TICK, 8'($urandom_range(0, 255)), pick_sda(40, 50));
    in_valid_i <= 1'b0;
    while (bus_states_due.size() != 0) @(posedge clk_i);
    run_to_idle(40, 50);
    send_idle_pct = saved_pct;
    settle();
  endtask

  // Random command sequences under random small settings
  task automatic test_random_traffic(input int n_words);
    int counted;
    int ack_pct;
    int low_pct;
    int pick;
    program_settings(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                     8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                     8'($urandom_range(0, 6)), 8'($urandom_range(0, 5)));
    counted = 0;
    ack_pct = 50;
    low_pct = 50;
    while (counted < n_words) begin
      pick = $urandom_range(0, 99);
      if (seq_phase == SEQ_IDLE) begin
        if (pick < 6) begin
          send_word(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (pick < 10) begin
          send_word(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          ack_pct = $urandom_range(0, 60);
          low_pct = $urandom_range(0, 100);
          send_word(3'($urandom_range(MODE_START, MODE_READ_NAK)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          counted++;
        end
      end else if (pick < 4) begin
        // command while busy, rejected
        send_word(3'($urandom_range(MODE_START, MODE_READ_NAK)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_word((pick < 8) ? 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)) : MODE_TICK,
                  8'($urandom_range(0, 255)), pick_sda(ack_pct, low_pct));
        counted++;
      end
    end
    run_to_idle(ack_pct, low_pct);
    settle();
  endtask

  // Receiver stall: forced hold-off first, otherwise random
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_states_due.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        head_state = bus_states_due.pop_front();
        compare_field("scl_level", 8'(out_scl_level_o), 8'(head_state.scl_level));
        compare_field("sda_level", 8'(out_sda_level_o), 8'(head_state.sda_level));
        compare_field("busy", 8'(out_busy_res_o), 8'(head_state.busy));
        compare_field("done", 8'(out_done_res_o), 8'(head_state.done));
        compare_field("rx_byte", out_rx_byte_o, head_state.rx_byte);
        compare_field("ack_error", 8'(out_ack_error_o), 8'(head_state.ack_error));
        compare_field("cmd_rejected", 8'(out_cmd_rejected_o),
                      8'(head_state.cmd_rejected));
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("i2c_master_byte_sequencer_core_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 69;
    test_reset_settings();
    test_zero_delays();
    test_ack_timeout();
    test_wide_delays();
    test_random_traffic(100);
    test_backpressure();
    test_random_traffic(100);

    send_idle_pct = 69;
    recv_idle_pct = 26;
    test_random_traffic(100);
    test_random_traffic(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100);
    test_random_traffic(100);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && bus_states_due.size() == 0) begin
      $display("i2c_master_byte_sequencer_core_test: PASS");
    end else begin
      $display("i2c_master_byte_sequencer_core_test: FAIL");
    end
    $finish;
  end

endmodule
